### design/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and codes for the sorted priority queue: entry layout,
// command and status codes, and the per-cell control word.
// ----------------------------------------------------------------------------
package spq_pkg;

	localparam int KEY_W    = 32;
	localparam int TAG_W    = 16;
	localparam int CMD_W    = 2;
	localparam int STATUS_W = 2;
	localparam int OCC_W    = 5;

	// Command codes
	localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
	localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
	localparam logic [CMD_W-1:0] CMD_VIEW   = 2'd2;
	localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd3;

	// Status codes
	localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

	// One stored entry
	typedef struct packed {
		logic             valid;
		logic [KEY_W-1:0] key;
		logic [TAG_W-1:0] tag;
	} spq_entry_t;

	// Operation broadcast to every cell of the chain
	typedef enum logic [2:0] {
		CELL_HOLD,
		CELL_INSERT,
		CELL_REMOVE,
		CELL_ROTATE,
		CELL_CLEAR
	} cell_op_t;

	typedef struct packed {
		cell_op_t         op;
		logic [KEY_W-1:0] key;
		logic [TAG_W-1:0] tag;
	} cell_ctrl_t;

endpackage

### design/spq_cell.sv
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted chain. Holds an entry, compares it against the
// broadcast key and takes data from itself, its neighbors or the head.
// ----------------------------------------------------------------------------
module spq_cell import spq_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  cell_ctrl_t ctrl,
	input  logic       prev_keep,
	input  spq_entry_t left,
	input  spq_entry_t right,
	input  spq_entry_t head,
	output spq_entry_t entry,
	output logic       keep
);

	logic             valid_q;
	logic [KEY_W-1:0] key_q;
	logic [TAG_W-1:0] tag_q;
	spq_entry_t       cur;
	spq_entry_t       entry_d;

	assign cur = {valid_q, key_q, tag_q};

	// Entry stays in place on insert when its key is smaller or equal
	assign keep  = cur.valid && (cur.key <= ctrl.key);
	assign entry = cur;

	// Next-entry selection
	always_comb begin
		entry_d = cur;
		case (ctrl.op)
			CELL_INSERT: begin
				if (!keep) begin
					if (prev_keep) begin
						entry_d.valid = 1'b1;
						entry_d.key   = ctrl.key;
						entry_d.tag   = ctrl.tag;
					end else begin
						entry_d = left;
					end
				end
			end
			CELL_REMOVE: begin
				entry_d = right;
			end
			CELL_ROTATE: begin
				// last valid cell wraps around to the head
				if (cur.valid) begin
					if (right.valid) begin
						entry_d = right;
					end else begin
						entry_d = head;
					end
				end
			end
			CELL_CLEAR: begin
				entry_d.valid = 1'b0;
			end
			default: begin
				entry_d = cur;
			end
		endcase
	end

	// Valid bit: control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= entry_d.valid;
		end
	end

	// Key and tag: payload
	always_ff @(posedge clk) begin
		key_q <= entry_d.key;
		tag_q <= entry_d.tag;
	end

endmodule

### design/sorted_priority_queue.sv
// ----------------------------------------------------------------------------
// sorted_priority_queue
// Bounded priority queue built as a chain of sorting cells.
// ----------------------------------------------------------------------------
// Entries sit in a row of CAPACITY cells in ascending key order, front in
// cell 0; equal keys leave in arrival order. Insert, remove and clear act
// on every cell in parallel: on insert each cell compares against the
// broadcast key and moves with its neighbors. View returns one beat per
// held entry, one per cycle while the output side is not stalling, by
// rotating the chain one step per beat so the front cell always carries
// the next entry; after the last beat the order is restored. A view of more
// than one entry holds off new commands until its last beat is loaded. Results
// leave through an output register, so the next command is taken while a
// result waits as long as the output side is not stalling.
module sorted_priority_queue import spq_pkg::*; #(
	parameter int CAPACITY = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [CMD_W-1:0]    command,
	input  logic [KEY_W-1:0]    key,
	input  logic [TAG_W-1:0]    tag,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [STATUS_W-1:0] status,
	output logic [KEY_W-1:0]    out_key,
	output logic [TAG_W-1:0]    out_tag,
	output logic [OCC_W-1:0]    occupancy,
	output logic                last
);

	localparam int CW = $clog2(CAPACITY + 1);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_VIEW = 1'b1;

	logic          state_q, state_d;
	logic [CW-1:0] count_q, count_d;
	logic [CW-1:0] remain_q, remain_d;

	logic                out_valid_q;
	logic [STATUS_W-1:0] status_q, status_d;
	logic [KEY_W-1:0]    out_key_q, out_key_d;
	logic [TAG_W-1:0]    out_tag_q, out_tag_d;
	logic [OCC_W-1:0]    occupancy_q, occupancy_d;
	logic                last_q, last_d;
	logic                load_out;

	logic       out_free;
	logic       accept;
	logic       full;
	logic       empty;
	cell_ctrl_t ctrl;

	spq_entry_t cell_entry [CAPACITY];
	logic       cell_keep  [CAPACITY];

	// Handshake
	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = (state_q == ST_VIEW) || !out_free;
	assign accept   = in_valid && !in_stall;

	assign full  = (count_q == CW'(CAPACITY));
	assign empty = (count_q == '0);

	// Cell chain
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		spq_entry_t left_w;
		spq_entry_t right_w;
		logic       prev_keep_w;

		if (i == 0) begin : g_first
			assign left_w      = '0;
			assign prev_keep_w = 1'b1;
		end else begin : g_mid_l
			assign left_w      = cell_entry[i-1];
			assign prev_keep_w = cell_keep[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign right_w = '0;
		end else begin : g_mid_r
			assign right_w = cell_entry[i+1];
		end

		spq_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctrl      (ctrl),
			.prev_keep (prev_keep_w),
			.left      (left_w),
			.right     (right_w),
			.head      (cell_entry[0]),
			.entry     (cell_entry[i]),
			.keep      (cell_keep[i])
		);
	end

	// Command sequencing
	always_comb begin
		state_d     = state_q;
		count_d     = count_q;
		remain_d    = remain_q;
		ctrl.op     = CELL_HOLD;
		ctrl.key    = key;
		ctrl.tag    = tag;
		load_out    = 1'b0;
		status_d    = STATUS_OK;
		out_key_d   = '0;
		out_tag_d   = '0;
		last_d      = 1'b1;

		if (state_q == ST_IDLE) begin
			if (accept) begin
				load_out = 1'b1;
				case (command)
					CMD_INSERT: begin
						if (full) begin
							status_d = STATUS_FULL;
						end else begin
							ctrl.op = CELL_INSERT;
							count_d = count_q + CW'(1);
						end
					end
					CMD_REMOVE: begin
						if (empty) begin
							status_d = STATUS_EMPTY;
						end else begin
							ctrl.op   = CELL_REMOVE;
							out_key_d = cell_entry[0].key;
							out_tag_d = cell_entry[0].tag;
							count_d   = count_q - CW'(1);
						end
					end
					CMD_VIEW: begin
						if (empty) begin
							status_d = STATUS_EMPTY;
						end else begin
							ctrl.op   = CELL_ROTATE;
							out_key_d = cell_entry[0].key;
							out_tag_d = cell_entry[0].tag;
							last_d    = (count_q == CW'(1));
							remain_d  = count_q - CW'(1);
							if (count_q != CW'(1)) begin
								state_d = ST_VIEW;
							end
						end
					end
					CMD_CLEAR: begin
						ctrl.op = CELL_CLEAR;
						count_d = '0;
					end
					default: begin
						load_out = 1'b1;
					end
				endcase
			end
		end else begin
			// stream the remaining entries of a view
			if (out_free) begin
				load_out  = 1'b1;
				ctrl.op   = CELL_ROTATE;
				out_key_d = cell_entry[0].key;
				out_tag_d = cell_entry[0].tag;
				last_d    = (remain_q == CW'(1));
				remain_d  = remain_q - CW'(1);
				if (remain_q == CW'(1)) begin
					state_d = ST_IDLE;
				end
			end
		end

		occupancy_d = OCC_W'(count_d);
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			remain_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			count_q  <= count_d;
			remain_q <= remain_d;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Output beat register
	always_ff @(posedge clk) begin
		if (load_out) begin
			status_q    <= status_d;
			out_key_q   <= out_key_d;
			out_tag_q   <= out_tag_d;
			occupancy_q <= occupancy_d;
			last_q      <= last_d;
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign out_key   = out_key_q;
	assign out_tag   = out_tag_q;
	assign occupancy = occupancy_q;
	assign last      = last_q;

endmodule
